[hdl/broadcast_reduce_index_map_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the broadcast/reduce index map unit
// Concurrent checks are sampled on clk and masked while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BROADCAST_REDUCE_INDEX_MAP_UNIT_DEFINES_SVH
`define BROADCAST_REDUCE_INDEX_MAP_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define BRIM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define BRIM_ASSERT_IMP(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) else $error(msg);
`else
`define BRIM_ASSERT(lbl, prop, msg)
`define BRIM_ASSERT_IMP(lbl, cond, prop, msg)
`endif

`endif

[hdl/brim_pkg.sv]
// ----------------------------------------------------------------------------
// brim_pkg
// Shared widths, codes, types and helpers of the index map unit.
// ----------------------------------------------------------------------------
package brim_pkg;

	localparam int RANK      = 4;
	localparam int DIM_W     = 16;
	localparam int IDX_W     = 20;
	localparam int POS_W     = 16;
	localparam int CNT_W     = IDX_W + 1;
	localparam int RANK_W    = 3;
	localparam int AXIS_W    = 2;
	localparam int DATA_W    = 64;
	localparam int REG_IDX_W = 3;
	localparam int DIV_STEPS = IDX_W;

	localparam logic [CNT_W-1:0] MAX_ELEMENTS = CNT_W'(1) << IDX_W;

	typedef enum logic [1:0] {
		FAULT_OK    = 2'd0,
		FAULT_SHAPE = 2'd1,
		FAULT_INDEX = 2'd2,
		FAULT_POS   = 2'd3
	} fault_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_OUT_SHAPE = 3'd0,
		REG_SRC_SHAPE = 3'd1,
		REG_OUT_RANK  = 3'd2,
		REG_SRC_RANK  = 3'd3,
		REG_MODE      = 3'd4,
		REG_SUM_AXIS  = 3'd5
	} reg_idx_t;

	// Per-configuration values derived from the registers; steady while they stay unchanged.
	typedef struct packed {
		logic                       shape_fault;
		logic                       mode;
		logic [AXIS_W-1:0]          ax;
		logic [CNT_W-1:0]           otot;
		logic [CNT_W-1:0]           stot;
		logic [RANK-1:0][DIM_W-1:0] s;
		logic [RANK-1:0][DIM_W-1:0] o;
		logic [RANK-1:0][CNT_W-1:0] stride;
	} derived_t;

	// One item in flight: dividend/quotient, partial remainder, position, sum, fault code.
	typedef struct packed {
		logic [IDX_W-1:0] n;
		logic [DIM_W-1:0] r;
		logic [POS_W-1:0] pos;
		logic [IDX_W-1:0] acc;
		fault_t           fault;
	} item_t;

	function automatic logic [RANK_W-1:0] eff_rank(input logic [RANK_W-1:0] r);
		if (r == '0)
			return RANK_W'(1);
		if (r > RANK_W'(RANK))
			return RANK_W'(RANK);
		return r;
	endfunction

	// Clamp an element count so that anything above the limit stays above it.
	function automatic logic [CNT_W-1:0] sat_cnt(input logic [2*DIM_W-1:0] p);
		if (p > (2*DIM_W)'(MAX_ELEMENTS))
			return MAX_ELEMENTS + CNT_W'(1);
		return p[CNT_W-1:0];
	endfunction

endpackage

[hdl/brim_if.sv]
// ----------------------------------------------------------------------------
// brim channel interfaces
// Request, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface brim_item_if;
	logic                        valid;
	logic                        ready;
	logic [brim_pkg::IDX_W-1:0]  out_index;
	logic [brim_pkg::POS_W-1:0]  reduce_pos;
	modport source (output valid, out_index, reduce_pos, input ready);
	modport sink (input valid, out_index, reduce_pos, output ready);
endinterface

interface brim_result_if;
	logic                        valid;
	logic                        ready;
	logic [brim_pkg::IDX_W-1:0]  src_index;
	logic [1:0]                  fault;
	modport source (output valid, src_index, fault, input ready);
	modport sink (input valid, src_index, fault, output ready);
endinterface

interface brim_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [brim_pkg::REG_IDX_W-1:0] index;
	logic [brim_pkg::DATA_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hdl/broadcast_reduce_index_map_unit.sv]
// ----------------------------------------------------------------------------
// broadcast_reduce_index_map_unit
// Maps a result tensor's linear index to the linear index of its source.
// ----------------------------------------------------------------------------
//
//   channel  | role   | request contents
//   ---------+--------+-------------------------------------------
//   item     | sink   | out_index, reduce_pos
//   result   | source | src_index, fault
//   cfg      | sink   | index, data (register write, always ready)
//
// One request enters and one result leaves per clock while the chain moves.
// The pipeline holds four alignment stages, one fault check, then for each
// of the four dimensions a chain of 20 division cells and one accumulate cell.
// The whole chain advances together; it holds when a result waits untaken.
// Reset clears the valid bits and restores the register defaults.
// Derived shape values settle once a register write has passed through brim_cfg.
// ----------------------------------------------------------------------------
`include "broadcast_reduce_index_map_unit_defines.svh"

module broadcast_reduce_index_map_unit (
	input  logic          clk,
	input  logic          arst_n,
	brim_item_if.sink     item,
	brim_result_if.source result,
	brim_cfg_if.sink      cfg
);

	brim_pkg::derived_t der;

	brim_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.der    (der)
	);

	// The chain moves whenever the output slot is empty or being drained.
	logic en;
	assign en         = !result.valid || result.ready;
	assign item.ready = en;

	// Front stages: the request passes the alignment registers, then the fault
	// check picks the highest-priority fault.
	logic            v_s1, v_s2, v_s3, v_s4, v_s5;
	brim_pkg::item_t i_s1, i_s2, i_s3, i_s4, i_s5;
	brim_pkg::item_t checked;

	always_comb begin
		checked = i_s4;
		if (der.shape_fault)
			checked.fault = brim_pkg::FAULT_SHAPE;
		else if (brim_pkg::CNT_W'(i_s4.n) >= der.otot)
			checked.fault = brim_pkg::FAULT_INDEX;
		else if (der.mode && i_s4.pos >= der.s[der.ax])
			checked.fault = brim_pkg::FAULT_POS;
		else
			checked.fault = brim_pkg::FAULT_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= item.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			i_s1.n     <= item.out_index;
			i_s1.r     <= '0;
			i_s1.pos   <= item.reduce_pos;
			i_s1.acc   <= '0;
			i_s1.fault <= brim_pkg::FAULT_OK;
			i_s2       <= i_s1;
			i_s3       <= i_s2;
			i_s4       <= i_s3;
			i_s5       <= checked;
		end
	end

	// Dimension chains, innermost first. Each division chain leaves the
	// coordinate in the remainder and the next dividend in the quotient.
	logic            dv [brim_pkg::RANK][brim_pkg::DIV_STEPS+1];
	brim_pkg::item_t di [brim_pkg::RANK][brim_pkg::DIV_STEPS+1];
	logic            av [brim_pkg::RANK];
	brim_pkg::item_t ai [brim_pkg::RANK];

	for (genvar d = 0; d < brim_pkg::RANK; d++) begin : g_dim
		if (d == 0) begin : g_head
			assign dv[d][0] = v_s5;
			assign di[d][0] = i_s5;
		end else begin : g_link
			assign dv[d][0] = av[d-1];
			assign di[d][0] = ai[d-1];
		end

		for (genvar k = 0; k < brim_pkg::DIV_STEPS; k++) begin : g_step
			brim_div_cell u_div (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.vld_in  (dv[d][k]),
				.item_in (di[d][k]),
				.divisor (der.o[d]),
				.vld_s1  (dv[d][k+1]),
				.item_s1 (di[d][k+1])
			);
		end

		brim_acc_cell u_acc (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.dim     (brim_pkg::AXIS_W'(d)),
			.der     (der),
			.vld_in  (dv[d][brim_pkg::DIV_STEPS]),
			.item_in (di[d][brim_pkg::DIV_STEPS]),
			.vld_s1  (av[d]),
			.item_s1 (ai[d])
		);
	end

	// The last accumulate cell is the output register; a faulted request
	// reports index zero.
	assign result.valid     = av[brim_pkg::RANK-1];
	assign result.fault     = ai[brim_pkg::RANK-1].fault;
	assign result.src_index = (ai[brim_pkg::RANK-1].fault == brim_pkg::FAULT_OK) ?
		ai[brim_pkg::RANK-1].acc : '0;

	`BRIM_ASSERT_IMP(a_fault_zero_index, result.valid && result.fault != brim_pkg::FAULT_OK, result.src_index == '0, "faulted result carries a nonzero index")
	`BRIM_ASSERT_IMP(a_pos_fault_sum_mode, result.valid && result.fault == brim_pkg::FAULT_POS, der.mode, "position fault outside sum mode")
	`BRIM_ASSERT_IMP(a_index_in_source, result.valid && result.fault == brim_pkg::FAULT_OK, brim_pkg::CNT_W'(result.src_index) < der.stot, "source index beyond source element count")

endmodule

[hdl/brim_cfg.sv]
// ----------------------------------------------------------------------------
// brim_cfg
// Register file and a four-stage pipeline deriving shapes, strides and counts.
// ----------------------------------------------------------------------------
module brim_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	brim_cfg_if.sink             cfg,
	output brim_pkg::derived_t   der
);

	localparam int P_W = 2 * brim_pkg::DIM_W;
	localparam int T_W = 2 * brim_pkg::CNT_W;

	logic [brim_pkg::DATA_W-1:0]  out_shape_q, src_shape_q;
	logic [brim_pkg::RANK_W-1:0]  out_rank_q, src_rank_q;
	logic                         mode_q;
	logic [brim_pkg::AXIS_W-1:0]  sum_axis_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_shape_q <= '0;
			src_shape_q <= '0;
			out_rank_q  <= brim_pkg::RANK_W'(1);
			src_rank_q  <= brim_pkg::RANK_W'(1);
			mode_q      <= 1'b0;
			sum_axis_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				brim_pkg::REG_OUT_SHAPE: out_shape_q <= cfg.data;
				brim_pkg::REG_SRC_SHAPE: src_shape_q <= cfg.data;
				brim_pkg::REG_OUT_RANK:  out_rank_q  <= cfg.data[brim_pkg::RANK_W-1:0];
				brim_pkg::REG_SRC_RANK:  src_rank_q  <= cfg.data[brim_pkg::RANK_W-1:0];
				brim_pkg::REG_MODE:      mode_q      <= cfg.data[0];
				brim_pkg::REG_SUM_AXIS:  sum_axis_q  <= cfg.data[brim_pkg::AXIS_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: effective shapes, broadcast or axis check and summed axis.
	logic [brim_pkg::RANK-1:0][brim_pkg::DIM_W-1:0] s_c, o_c, s_s1, o_s1;
	logic [brim_pkg::RANK_W-1:0] sr, orr;
	logic [brim_pkg::AXIS_W-1:0] ax_c, ax_s1;
	logic                        bad_c, bad_s1, mode_s1;

	always_comb begin
		sr   = brim_pkg::eff_rank(src_rank_q);
		orr  = brim_pkg::eff_rank(out_rank_q);
		ax_c = brim_pkg::AXIS_W'(sr - brim_pkg::RANK_W'(1) - brim_pkg::RANK_W'(sum_axis_q));
		bad_c = 1'b0;
		for (int i = 0; i < brim_pkg::RANK; i++) begin
			s_c[i] = (brim_pkg::RANK_W'(i) < sr) ?
				src_shape_q[i*brim_pkg::DIM_W +: brim_pkg::DIM_W] : brim_pkg::DIM_W'(1);
			o_c[i] = (brim_pkg::RANK_W'(i) < orr) ?
				out_shape_q[i*brim_pkg::DIM_W +: brim_pkg::DIM_W] : brim_pkg::DIM_W'(1);
		end
		if (!mode_q) begin
			for (int i = 0; i < brim_pkg::RANK; i++)
				if (s_c[i] != brim_pkg::DIM_W'(1) && s_c[i] != o_c[i])
					bad_c = 1'b1;
		end else begin
			bad_c = brim_pkg::RANK_W'(sum_axis_q) >= sr;
			o_c   = s_c;
			o_c[ax_c] = brim_pkg::DIM_W'(1);
		end
	end

	// Stage 2: pairwise products, clamped above the element limit.
	logic [brim_pkg::CNT_W-1:0] ps01_s2, ps23_s2, po01_s2, po23_s2;
	logic [brim_pkg::RANK-1:0][brim_pkg::DIM_W-1:0] s_s2, o_s2;
	logic [brim_pkg::AXIS_W-1:0] ax_s2;
	logic                        bad_s2, mode_s2;

	// Stage 3: full counts and the outermost stride.
	logic [T_W-1:0]               stot_s3, otot_s3;
	logic [brim_pkg::CNT_W-1:0]   str3_s3, ps01_s3;
	logic [brim_pkg::RANK-1:0][brim_pkg::DIM_W-1:0] s_s3, o_s3;
	logic [brim_pkg::AXIS_W-1:0] ax_s3;
	logic                        bad_s3, mode_s3;
	logic [T_W-1:0]              str3_full;

	assign str3_full = T_W'(ps01_s2) * T_W'(s_s2[2]);

	always_ff @(posedge clk) begin
		s_s1    <= s_c;
		o_s1    <= o_c;
		ax_s1   <= ax_c;
		bad_s1  <= bad_c;
		mode_s1 <= mode_q;

		ps01_s2 <= brim_pkg::sat_cnt(P_W'(s_s1[0]) * P_W'(s_s1[1]));
		ps23_s2 <= brim_pkg::sat_cnt(P_W'(s_s1[2]) * P_W'(s_s1[3]));
		po01_s2 <= brim_pkg::sat_cnt(P_W'(o_s1[0]) * P_W'(o_s1[1]));
		po23_s2 <= brim_pkg::sat_cnt(P_W'(o_s1[2]) * P_W'(o_s1[3]));
		s_s2    <= s_s1;
		o_s2    <= o_s1;
		ax_s2   <= ax_s1;
		bad_s2  <= bad_s1;
		mode_s2 <= mode_s1;

		stot_s3 <= T_W'(ps01_s2) * T_W'(ps23_s2);
		otot_s3 <= T_W'(po01_s2) * T_W'(po23_s2);
		str3_s3 <= str3_full[brim_pkg::CNT_W-1:0];
		ps01_s3 <= ps01_s2;
		s_s3    <= s_s2;
		o_s3    <= o_s2;
		ax_s3   <= ax_s2;
		bad_s3  <= bad_s2;
		mode_s3 <= mode_s2;

		der.shape_fault <= bad_s3 || stot_s3 > T_W'(brim_pkg::MAX_ELEMENTS)
			|| otot_s3 > T_W'(brim_pkg::MAX_ELEMENTS);
		der.mode      <= mode_s3;
		der.ax        <= ax_s3;
		der.otot      <= otot_s3[brim_pkg::CNT_W-1:0];
		der.stot      <= stot_s3[brim_pkg::CNT_W-1:0];
		der.s         <= s_s3;
		der.o         <= o_s3;
		der.stride[0] <= brim_pkg::CNT_W'(1);
		der.stride[1] <= brim_pkg::CNT_W'(s_s3[0]);
		der.stride[2] <= ps01_s3;
		der.stride[3] <= str3_s3;
	end

endmodule

[hdl/brim_div_cell.sv]
// ----------------------------------------------------------------------------
// brim_div_cell
// One restoring-division step: shifts in a dividend bit, forms a quotient bit.
// ----------------------------------------------------------------------------
module brim_div_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_in,
	input  brim_pkg::item_t             item_in,
	input  logic [brim_pkg::DIM_W-1:0]  divisor,
	output logic                        vld_s1,
	output brim_pkg::item_t             item_s1
);

	logic [brim_pkg::DIM_W:0] trial;
	logic                     ge;
	brim_pkg::item_t          nxt;

	always_comb begin
		trial = {item_in.r, item_in.n[brim_pkg::IDX_W-1]};
		ge    = trial >= {1'b0, divisor};
		nxt   = item_in;
		nxt.r = ge ? brim_pkg::DIM_W'(trial - {1'b0, divisor}) : trial[brim_pkg::DIM_W-1:0];
		nxt.n = {item_in.n[brim_pkg::IDX_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s1 <= nxt;
	end

endmodule

[hdl/brim_acc_cell.sv]
// ----------------------------------------------------------------------------
// brim_acc_cell
// Adds one dimension's coordinate times stride: remainder, sum pos, or 0.
// ----------------------------------------------------------------------------
module brim_acc_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [brim_pkg::AXIS_W-1:0]  dim,
	input  brim_pkg::derived_t           der,
	input  logic                         vld_in,
	input  brim_pkg::item_t              item_in,
	output logic                         vld_s1,
	output brim_pkg::item_t              item_s1
);

	localparam int M_W = brim_pkg::DIM_W + brim_pkg::CNT_W;

	logic [brim_pkg::DIM_W-1:0] digit;
	logic [M_W-1:0]             prod;
	brim_pkg::item_t            nxt;

	always_comb begin
		if (der.mode && dim == der.ax)
			digit = item_in.pos;
		else if (der.s[dim] == brim_pkg::DIM_W'(1))
			digit = '0;
		else
			digit = item_in.r;
		prod    = M_W'(digit) * M_W'(der.stride[dim]);
		nxt     = item_in;
		nxt.acc = item_in.acc + prod[brim_pkg::IDX_W-1:0];
		nxt.r   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s1 <= nxt;
	end

endmodule

[test/broadcast_reduce_index_map_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// broadcast_reduce_index_map_unit_tb
// Self-checking bench for the index map unit. A predictor in the bench maps
// every accepted request to its expected source index and fault code, and a
// checker compares each result with the oldest expectation. Directed tests
// cover the reset shapes, broadcast and sum mode, every fault and the rank
// clamps; random phases then reconfigure the block and stream requests with
// bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module broadcast_reduce_index_map_unit_tb;

	localparam int LATENCY     = 89;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic [brim_pkg::IDX_W-1:0] src_index;
		brim_pkg::fault_t           fault;
	} mapped_t;

	logic clk;
	logic arst_n;

	brim_item_if   item ();
	brim_result_if result ();
	brim_cfg_if    cfg ();

	broadcast_reduce_index_map_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	// The bench's own copy of the registers, updated when a write is accepted.
	logic [brim_pkg::DATA_W-1:0] out_shape_reg;
	logic [brim_pkg::DATA_W-1:0] src_shape_reg;
	logic [brim_pkg::RANK_W-1:0] out_rank_reg;
	logic [brim_pkg::RANK_W-1:0] src_rank_reg;
	logic                        mode_reg;
	logic [brim_pkg::AXIS_W-1:0] sum_axis_reg;

	mapped_t pending_maps[$];
	int      errors;
	int      cycles;
	int      burst_left;
	bit      hold_off;

	// Clock with a 2 ns period.
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Runaway guard: the slowest correct run stays far below this count.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("broadcast_reduce_index_map_unit test failed");
			$finish;
		end
	end

	function automatic int unsigned clamp_rank(input logic [brim_pkg::RANK_W-1:0] r);
		if (r == 0)
			return 1;
		if (r > brim_pkg::RANK)
			return brim_pkg::RANK;
		return r;
	endfunction

	// Predictor: maps one result index to the source index it reads. Both
	// shapes are right-aligned; missing outer dimensions count as size 1.
	// It also returns the result element count, which the stimulus uses to
	// aim most indexes inside the tensor.
	function automatic void map_index(input logic [brim_pkg::IDX_W-1:0] idx,
			input logic [brim_pkg::POS_W-1:0] pos, output mapped_t m,
			output longint unsigned total);
		longint unsigned s[brim_pkg::RANK];
		longint unsigned o[brim_pkg::RANK];
		longint unsigned stot, otot, acc, rem, stride, c;
		int unsigned sr, orr, ax;
		brim_pkg::fault_t f;
		stot = 1;
		otot = 1;
		acc = 0;
		ax = 0;
		f = brim_pkg::FAULT_OK;
		sr = clamp_rank(src_rank_reg);
		orr = clamp_rank(out_rank_reg);
		for (int i = 0; i < brim_pkg::RANK; i++) begin
			s[i] = (i < sr) ? longint'((src_shape_reg >> (16 * i)) & 16'hFFFF) : 1;
			o[i] = (i < orr) ? longint'((out_shape_reg >> (16 * i)) & 16'hFFFF) : 1;
		end
		if (!mode_reg) begin
			// A result size of 1 does not excuse a larger source size.
			for (int i = 0; i < brim_pkg::RANK; i++)
				if (s[i] != 1 && s[i] != o[i])
					f = brim_pkg::FAULT_SHAPE;
		end else if (sum_axis_reg >= sr) begin
			f = brim_pkg::FAULT_SHAPE;
		end else begin
			// The summed axis counts from the outermost used dimension.
			ax = sr - 1 - sum_axis_reg;
			for (int i = 0; i < brim_pkg::RANK; i++)
				o[i] = s[i];
			o[ax] = 1;
		end
		for (int i = 0; i < brim_pkg::RANK; i++) begin
			stot *= s[i];
			otot *= o[i];
		end
		if (f == brim_pkg::FAULT_OK && (stot > 64'd1048576 || otot > 64'd1048576))
			f = brim_pkg::FAULT_SHAPE;
		if (f == brim_pkg::FAULT_OK && idx >= otot)
			f = brim_pkg::FAULT_INDEX;
		if (f == brim_pkg::FAULT_OK && mode_reg && pos >= s[ax])
			f = brim_pkg::FAULT_POS;
		if (f == brim_pkg::FAULT_OK) begin
			rem = idx;
			stride = 1;
			for (int i = 0; i < brim_pkg::RANK; i++) begin
				c = 0;
				if (o[i] != 0) begin
					c = rem % o[i];
					rem = rem / o[i];
				end
				if (mode_reg && i == ax)
					c = pos;
				else if (s[i] == 1)
					c = 0;
				acc += c * stride;
				stride *= s[i];
			end
		end
		m.src_index = acc[brim_pkg::IDX_W-1:0];
		m.fault = f;
		total = otot;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	// Checker: every accepted result is matched against the oldest expectation.
	always @(posedge clk) begin
		mapped_t want;
		if (arst_n && result.valid && result.ready) begin
			if (pending_maps.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = pending_maps.pop_front();
				if (result.src_index !== want.src_index)
					report_mismatch($sformatf("src_index got %0h expected %0h",
						result.src_index, want.src_index));
				if (result.fault !== want.fault)
					report_mismatch($sformatf("fault got %0d expected %0d",
						result.fault, want.fault));
			end
		end
	end

	// Receiver: stretches of random length, each with its own stall pattern.
	// The hold-off flag forces a long stall so that the pipeline fills up.
	initial begin
		int stretch;
		int style;
		stretch = 0;
		style = 0;
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stretch == 0) begin
				stretch = $urandom_range(20, 200);
				style = $urandom_range(0, 2);
			end
			stretch--;
			if (hold_off)
				result.ready <= 1'b0;
			else if (style == 0)
				result.ready <= 1'b1;
			else if (style == 1)
				result.ready <= 1'($urandom_range(0, 1));
			else
				result.ready <= ($urandom_range(0, 7) != 0);
		end
	end

	task automatic idle_input(input int n);
		item.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Send one request. Valid stays high into the next request unless the
	// burst ends here, in which case the input idles for a random gap.
	task automatic send_req(input logic [brim_pkg::IDX_W-1:0] idx,
			input logic [brim_pkg::POS_W-1:0] pos);
		mapped_t m;
		longint unsigned total;
		item.valid <= 1'b1;
		item.out_index <= idx;
		item.reduce_pos <= pos;
		do
			@(posedge clk);
		while (!item.ready);
		map_index(idx, pos, m, total);
		pending_maps = {pending_maps, m};
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(0, 30);
			idle_input($urandom_range(1, 6));
		end else begin
			burst_left--;
		end
	endtask

	// Wait until every expected result has come, then let the pipeline empty.
	task automatic wait_drained();
		idle_input(1);
		while (pending_maps.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	// Register write; the mirror copy masks the data as the register does.
	// Valid is left high so that writes can follow back to back.
	task automatic write_reg(input brim_pkg::reg_idx_t r,
			input logic [brim_pkg::DATA_W-1:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= r;
		cfg.data <= d;
		do
			@(posedge clk);
		while (!cfg.ready);
		case (r)
			brim_pkg::REG_OUT_SHAPE: out_shape_reg = d;
			brim_pkg::REG_SRC_SHAPE: src_shape_reg = d;
			brim_pkg::REG_OUT_RANK:  out_rank_reg = d[brim_pkg::RANK_W-1:0];
			brim_pkg::REG_SRC_RANK:  src_rank_reg = d[brim_pkg::RANK_W-1:0];
			brim_pkg::REG_MODE:      mode_reg = d[0];
			brim_pkg::REG_SUM_AXIS:  sum_axis_reg = d[brim_pkg::AXIS_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Write all six registers; upper data bits of the narrow ones are noise.
	task automatic configure(input logic [brim_pkg::DATA_W-1:0] os,
			input logic [brim_pkg::DATA_W-1:0] ss,
			input logic [brim_pkg::RANK_W-1:0] orr, input logic [brim_pkg::RANK_W-1:0] sr,
			input logic md, input logic [brim_pkg::AXIS_W-1:0] ax);
		logic [brim_pkg::DATA_W-1:0] noise;
		wait_drained();
		noise = {$urandom, $urandom};
		write_reg(brim_pkg::REG_OUT_SHAPE, os);
		write_reg(brim_pkg::REG_SRC_SHAPE, ss);
		write_reg(brim_pkg::REG_OUT_RANK, {noise[brim_pkg::DATA_W-1:brim_pkg::RANK_W], orr});
		write_reg(brim_pkg::REG_SRC_RANK, {noise[brim_pkg::DATA_W-1:brim_pkg::RANK_W], sr});
		write_reg(brim_pkg::REG_MODE, {noise[brim_pkg::DATA_W-1:1], md});
		write_reg(brim_pkg::REG_SUM_AXIS, {noise[brim_pkg::DATA_W-1:brim_pkg::AXIS_W], ax});
		cfg.valid <= 1'b0;
		// Wait for the derived shape values to settle after a write.
		repeat (8) @(negedge clk);
	endtask

	// Random request: mostly inside the tensor, sometimes any 20-bit index.
	task automatic send_random_req();
		mapped_t m;
		longint unsigned total;
		logic [brim_pkg::IDX_W-1:0] idx;
		logic [brim_pkg::POS_W-1:0] pos;
		map_index('0, '0, m, total);
		if (total == 0 || total > 64'd1048576 || $urandom_range(0, 9) == 0)
			idx = brim_pkg::IDX_W'($urandom);
		else
			idx = brim_pkg::IDX_W'($urandom_range(0, int'(total - 1)));
		if ($urandom_range(0, 9) == 0)
			pos = brim_pkg::POS_W'($urandom);
		else
			pos = brim_pkg::POS_W'($urandom_range(0, 9));
		send_req(idx, pos);
	endtask

	// Reset leaves both shapes at zero, so every index is out of range.
	task automatic test_reset_defaults();
		send_req('0, '0);
		send_req('1, '1);
	endtask

	// Broadcast of a 3x1x5 source to a 2x3x4x5 result, plus index extremes.
	task automatic test_broadcast();
		configure({16'd2, 16'd3, 16'd4, 16'd5}, {16'd0, 16'd3, 16'd1, 16'd5},
			3'd4, 3'd3, 1'b0, 2'd0);
		send_req(20'd0, 16'hFFFF);
		send_req(20'd37, 16'd0);
		send_req(20'd119, 16'd0);
		send_req(20'd120, 16'd0);
		send_req('1, 16'h5555);
		// Source larger than the result, even where the result size is 1.
		configure({16'd1, 16'd1, 16'd1, 16'd5}, {16'd0, 16'd0, 16'd7, 16'd5},
			3'd4, 3'd2, 1'b0, 2'd0);
		send_req(20'd0, 16'd0);
		// A source of higher rank than the result cannot broadcast.
		configure({16'd9, 16'd9, 16'd4, 16'd5}, {16'd0, 16'd2, 16'd4, 16'd5},
			3'd2, 3'd3, 1'b0, 2'd0);
		send_req(20'd3, 16'd0);
	endtask

	// Sum mode on a 2x3x4x5 source: every axis, position extremes and the
	// position fault, plus an axis beyond the source rank.
	task automatic test_sum_axes();
		for (int a = 0; a < brim_pkg::RANK; a++) begin
			configure('1, {16'd2, 16'd3, 16'd4, 16'd5}, 3'd0, 3'd4, 1'b1,
				brim_pkg::AXIS_W'(a));
			send_req(20'd1, 16'd1);
			send_req(20'd7, 16'd5);
			send_req(20'd0, 16'hFFFF);
		end
		configure('0, {16'd2, 16'd3, 16'd4, 16'd5}, 3'd7, 3'd2, 1'b1, 2'd3);
		send_req(20'd0, 16'd0);
	endtask

	// Element counts above the limit, zero sizes and the rank clamps.
	task automatic test_size_limits();
		configure('1, '1, 3'd7, 3'd7, 1'b0, 2'd3);
		send_req(20'd5, 16'd0);
		configure({16'd0, 16'd0, 16'd0, 16'hFFFF}, {16'd0, 16'd0, 16'd0, 16'h0001},
			3'd0, 3'd0, 1'b0, 2'd0);
		send_req(20'hFFFE, 16'd0);
		configure({16'd3, 16'd0, 16'd4, 16'd5}, {16'd3, 16'd0, 16'd1, 16'd5},
			3'd4, 3'd4, 1'b0, 2'd0);
		send_req(20'd0, 16'd0);
		// Exactly the element limit is still fine.
		configure({16'd16, 16'd16, 16'd64, 16'd64}, {16'd16, 16'd1, 16'd64, 16'd1},
			3'd4, 3'd4, 1'b0, 2'd0);
		send_req(20'hFFFFF, 16'd0);
		send_req(20'hAAAAA, 16'd0);
	endtask

	// The receiver holds off long enough to fill the pipeline while the input
	// keeps offering requests; afterward the input waits for every result.
	task automatic test_backpressure();
		configure({16'd2, 16'd3, 16'd4, 16'd5}, {16'd2, 16'd1, 16'd4, 16'd1},
			3'd4, 3'd4, 1'b0, 2'd0);
		fork
			begin
				hold_off = 1'b1;
				repeat (400) @(negedge clk);
				hold_off = 1'b0;
			end
		join_none
		repeat (150)
			send_random_req();
		wait_drained();
		repeat (40)
			send_random_req();
	endtask

	function automatic logic [brim_pkg::DIM_W-1:0] random_dim();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			return '0;
		if (pick < 8)
			return brim_pkg::DIM_W'($urandom);
		return brim_pkg::DIM_W'($urandom_range(1, 8));
	endfunction

	// Random phases: new shapes, ranks, mode and axis, then a stream.
	task automatic test_random_phases();
		logic [brim_pkg::DATA_W-1:0] os, ss;
		logic [brim_pkg::RANK_W-1:0] orr, sr;
		for (int p = 0; p < 12; p++) begin
			for (int d = 0; d < brim_pkg::RANK; d++) begin
				os[16*d +: 16] = random_dim();
				case ($urandom_range(0, 9))
					0: ss[16*d +: 16] = random_dim();
					1, 2, 3: ss[16*d +: 16] = 16'd1;
					default: ss[16*d +: 16] = os[16*d +: 16];
				endcase
			end
			orr = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
			sr = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
			configure(os, ss, orr, sr, 1'($urandom), 2'($urandom));
			repeat (75)
				send_random_req();
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		burst_left = 0;
		hold_off = 1'b0;
		arst_n = 1'b0;
		item.valid = 1'b0;
		item.out_index = '0;
		item.reduce_pos = '0;
		cfg.valid = 1'b0;
		cfg.index = brim_pkg::REG_OUT_SHAPE;
		cfg.data = '0;
		out_shape_reg = '0;
		src_shape_reg = '0;
		out_rank_reg = 3'd1;
		src_rank_reg = 3'd1;
		mode_reg = 1'b0;
		sum_axis_reg = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (8) @(negedge clk);

		test_reset_defaults();
		test_broadcast();
		test_sum_axes();
		test_size_limits();
		test_backpressure();
		test_random_phases();
		wait_drained();

		if (errors == 0)
			$display("broadcast_reduce_index_map_unit test passed");
		else
			$display("broadcast_reduce_index_map_unit test failed");
		$finish;
	end

endmodule
